@@ design/gncf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gncf_pkg
// Shared constants, types and helpers of the grid node friction collision
// pipeline.
// ----------------------------------------------------------------------------
package gncf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int VEL_W     = 32;
   localparam int NRM_W     = 18;
   localparam int FC_W      = 19;
   localparam logic [FC_W-1:0] FC_RESET = FC_W'(13107);

   localparam int PROD_W  = VEL_W + NRM_W;          // v*n
   localparam int DOT_W   = PROD_W + 2;             // sum of three
   localparam int VN_W    = DOT_W - FRAC_BITS;      // rounded normal speed
   localparam int NVN_W   = VN_W - 1;               // approach speed magnitude
   localparam int PN_W    = VN_W + NRM_W;           // vn*n
   localparam int FULL_W  = PN_W + 2;               // v*2^F - vn*n
   localparam int LIM_W   = FC_W + NVN_W;           // friction limit
   localparam int SQ_W    = 2 * VEL_W;              // squared magnitude
   localparam int MAG_W   = VEL_W;                  // magnitude
   localparam int REM_W   = MAG_W + 4;              // root remainder
   localparam int NUM_W   = MAG_W + FRAC_BITS + 1;  // divider numerator
   localparam int S_W     = FRAC_BITS + 1;          // scale factor
   localparam int SP_W    = VEL_W + S_W + 1;        // t*s

   localparam int SQRT_STAGES = MAG_W;
   localparam int DIV_STAGES  = S_W;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_FRICTION = CSR_ADDR_W'(0);

   typedef enum logic [1:0] {
      KIND_PASS  = 2'd0,
      KIND_SLIDE = 2'd1,
      KIND_STICK = 2'd2
   } kind_type;

   typedef struct packed {
      logic                         contact;
      logic                         stick;
      logic [2:0][VEL_W-1:0]        tan;
      logic [2:0][VEL_W-1:0]        vel;
      logic [LIM_W-1:0]             lim;
   } side_type;

   localparam int SAT_IN_W = 64;

   function automatic logic [VEL_W-1:0] sat_vel(input logic signed [SAT_IN_W-1:0] x);
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      hi = SAT_IN_W'(signed'({1'b0, {(VEL_W-1){1'b1}}}));
      lo = -hi - SAT_IN_W'(1);
      if (x > hi) begin
         return {1'b0, {(VEL_W-1){1'b1}}};
      end else if (x < lo) begin
         return {1'b1, {(VEL_W-1){1'b0}}};
      end
      return x[VEL_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ design/gncf_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gncf_sqrt
// Pipelined integer square root, one root bit per stage, sideband carried.
// ----------------------------------------------------------------------------
module gncf_sqrt import gncf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic [SQRT_STAGES-1:0] en,
   input  wire logic [SQ_W-1:0]        rad_in,
   input  wire side_type               side_in,
   output logic [MAG_W-1:0]            root_out,
   output side_type                    side_out
);

   logic [SQ_W-1:0]  rad_ff  [SQRT_STAGES];
   logic [REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [MAG_W-1:0] root_ff [SQRT_STAGES];
   side_type         side_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [SQ_W-1:0]  rad_prev;
      logic [REM_W-1:0] rem_prev;
      logic [MAG_W-1:0] root_prev;
      side_type         side_prev;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic [SQ_W-1:0]  rad_in_k;
      logic [REM_W-1:0] rem_in;
      logic [MAG_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rad_prev  = rad_in;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         // bring down the next two radicand bits and try root*4+1
         rem_sh   = {rem_prev[REM_W-3:0], rad_prev[SQ_W-1 -: 2]};
         trial    = {2'b00, root_prev, 2'b01};
         rad_in_k = {rad_prev[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[MAG_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[MAG_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rad_ff[k]  <= rad_in_k;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES-1];
   assign side_out = side_ff[SQRT_STAGES-1];

endmodule
`default_nettype wire

@@ design/gncf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gncf_div
// Pipelined restoring divider, one quotient bit per stage, sideband carried.
// ----------------------------------------------------------------------------
module gncf_div import gncf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic [DIV_STAGES-1:0] en,
   input  wire logic [NUM_W-1:0]      num_in,
   input  wire logic [MAG_W-1:0]      den_in,
   input  wire side_type              side_in,
   output logic [S_W-1:0]             quo_out,
   output side_type                   side_out
);

   logic [NUM_W-1:0] num_ff  [DIV_STAGES];
   logic [MAG_W-1:0] den_ff  [DIV_STAGES];
   logic [S_W-1:0]   quo_ff  [DIV_STAGES];
   side_type         side_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int BIT = DIV_STAGES - 1 - k;
      logic [NUM_W-1:0] num_prev;
      logic [MAG_W-1:0] den_prev;
      logic [S_W-1:0]   quo_prev;
      side_type         side_prev;
      logic [NUM_W-1:0] den_sh;
      logic [NUM_W-1:0] num_next;
      logic [S_W-1:0]   quo_next;

      if (k == 0) begin : g_first
         assign num_prev  = num_in;
         assign den_prev  = den_in;
         assign quo_prev  = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign num_prev  = num_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         den_sh   = NUM_W'(den_prev) << BIT;
         num_next = num_prev;
         quo_next = quo_prev;
         if (num_prev >= den_sh) begin
            num_next      = num_prev - den_sh;
            quo_next[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            num_ff[k]  <= num_next;
            den_ff[k]  <= den_prev;
            quo_ff[k]  <= quo_next;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign quo_out  = quo_ff[DIV_STAGES-1];
   assign side_out = side_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ design/grid_node_friction_collision.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_node_friction_collision
// Coulomb friction velocity projection of one grid node per beat.
// ----------------------------------------------------------------------------
// One node enters per clock while the first stage is empty or advancing
// (req_tready). The 32-stage square root (one root bit per stage) and the
// 17-stage divider (one scale bit per stage) sit between the dot product,
// tangent and friction-limit stages and the final scale multiply.
// Every stage holds its own valid bit and advances whenever the stage below
// it is empty or moving, so bubbles close up and new beats keep entering
// while a finished result waits on rsp_tready. Nodes inside the obstacle and
// approaching it stick (zero velocity, kind 2) or slide with a shortened
// tangential velocity (kind 1); all others pass unchanged (kind 0). Write
// friction_coeff at address 0 only while the pipeline is empty.
// ----------------------------------------------------------------------------
module grid_node_friction_collision import gncf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // level_value, normal_x, normal_y, normal_z, vel_in_x, vel_in_y, vel_in_z
   input  wire logic [183:0]          req_tdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // vel_out_x, vel_out_y, vel_out_z
   output logic [95:0]                rsp_tdata,
   // contact_kind
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int ST_PROD = 0;
   localparam int ST_DOT  = 1;
   localparam int ST_PN   = 2;
   localparam int ST_TAN  = 3;
   localparam int ST_SQ   = 4;
   localparam int ST_SUM  = 5;
   localparam int ST_SQRT = 6;
   localparam int ST_CMP  = ST_SQRT + SQRT_STAGES;
   localparam int ST_DIV  = ST_CMP + 1;
   localparam int ST_MUL  = ST_DIV + DIV_STAGES;
   localparam int ST_OUT  = ST_MUL + 1;
   localparam int NSTAGE  = ST_OUT + 1;

   // ---------------- configuration ----------------
   logic [FC_W-1:0] fc_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= FC_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == REG_FRICTION) begin
         fc_ff <= csr_pwdata[FC_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == REG_FRICTION) ? 32'(fc_ff) : 32'd0;

   // ---------------- stage flow control ----------------
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] en;

   always_comb begin
      // a stage advances when it is empty or the stage below advances
      en[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[NSTAGE-1];

   // ---------------- input unpack ----------------
   logic signed [VEL_W-1:0] in_level;
   logic signed [NRM_W-1:0] in_n [3];
   logic signed [VEL_W-1:0] in_v [3];

   always_comb begin
      in_level = req_tdata[31:0];
      in_n[0]  = req_tdata[49:32];
      in_n[1]  = req_tdata[67:50];
      in_n[2]  = req_tdata[85:68];
      in_v[0]  = req_tdata[117:86];
      in_v[1]  = req_tdata[149:118];
      in_v[2]  = req_tdata[181:150];
   end

   // ---------------- products v*n ----------------
   logic signed [PROD_W-1:0] p1_prod_ff [3];
   logic signed [NRM_W-1:0]  p1_n_ff    [3];
   logic signed [VEL_W-1:0]  p1_v_ff    [3];
   logic                     p1_inside_ff;

   always_ff @(posedge clock) begin
      if (en[ST_PROD]) begin
         for (int i = 0; i < 3; i++) begin
            p1_prod_ff[i] <= PROD_W'(in_v[i]) * PROD_W'(in_n[i]);
            p1_n_ff[i]    <= in_n[i];
            p1_v_ff[i]    <= in_v[i];
         end
         p1_inside_ff <= (in_level <= 0);
      end
   end

   // ---------------- dot, approach test, rounded vn ----------------
   logic signed [DOT_W-1:0] p2_dot;
   logic signed [DOT_W-1:0] p2_dot_rnd;
   logic signed [VN_W-1:0]  p2_vn_ff;
   logic signed [NRM_W-1:0] p2_n_ff [3];
   logic signed [VEL_W-1:0] p2_v_ff [3];
   logic                    p2_contact_ff;

   always_comb begin
      p2_dot     = DOT_W'(p1_prod_ff[0]) + DOT_W'(p1_prod_ff[1]) + DOT_W'(p1_prod_ff[2]);
      p2_dot_rnd = p2_dot + (DOT_W'(1) <<< (FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (en[ST_DOT]) begin
         p2_vn_ff      <= p2_dot_rnd[DOT_W-1:FRAC_BITS];
         p2_contact_ff <= p1_inside_ff && (p2_dot < 0);
         p2_n_ff       <= p1_n_ff;
         p2_v_ff       <= p1_v_ff;
      end
   end

   // ---------------- vn*n ----------------
   logic signed [PN_W-1:0]  p3_pn_ff [3];
   logic signed [VEL_W-1:0] p3_v_ff  [3];
   logic [NVN_W-1:0]        p3_nvn_ff;
   logic                    p3_contact_ff;
   logic signed [VN_W-1:0]  p3_nvn_full;

   assign p3_nvn_full = -p2_vn_ff;

   always_ff @(posedge clock) begin
      if (en[ST_PN]) begin
         for (int i = 0; i < 3; i++) begin
            p3_pn_ff[i] <= PN_W'(p2_vn_ff) * PN_W'(p2_n_ff[i]);
         end
         p3_v_ff       <= p2_v_ff;
         p3_nvn_ff     <= p3_nvn_full[NVN_W-1:0];
         p3_contact_ff <= p2_contact_ff;
      end
   end

   // ---------------- tangent components and friction limit ----------------
   logic signed [FULL_W-1:0] p4_full [3];
   side_type                 p4_side;
   side_type                 p4_side_ff;

   always_comb begin
      p4_side         = '0;
      p4_side.contact = p3_contact_ff;
      p4_side.lim     = LIM_W'(fc_ff) * LIM_W'(p3_nvn_ff);
      for (int i = 0; i < 3; i++) begin
         p4_full[i]     = (FULL_W'(p3_v_ff[i]) <<< FRAC_BITS) - FULL_W'(p3_pn_ff[i])
                          + (FULL_W'(1) <<< (FRAC_BITS - 1));
         p4_side.tan[i] = sat_vel(SAT_IN_W'(p4_full[i] >>> FRAC_BITS));
         p4_side.vel[i] = p3_v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_TAN]) begin
         p4_side_ff <= p4_side;
      end
   end

   // ---------------- squares ----------------
   logic [SQ_W-1:0] p5_sq_ff [3];
   side_type        p5_side_ff;

   always_ff @(posedge clock) begin
      if (en[ST_SQ]) begin
         for (int i = 0; i < 3; i++) begin
            p5_sq_ff[i] <= SQ_W'($signed(p4_side_ff.tan[i]) * $signed(p4_side_ff.tan[i]));
         end
         p5_side_ff <= p4_side_ff;
      end
   end

   // ---------------- sum of squares ----------------
   logic [SQ_W-1:0] p6_sum_ff;
   side_type        p6_side_ff;

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         p6_sum_ff  <= p5_sq_ff[0] + p5_sq_ff[1] + p5_sq_ff[2];
         p6_side_ff <= p5_side_ff;
      end
   end

   // ---------------- magnitude ----------------
   logic [MAG_W-1:0] sq_root;
   side_type         sq_side;

   gncf_sqrt u_sqrt (
      .clock    (clock),
      .en       (en[ST_SQRT +: SQRT_STAGES]),
      .rad_in   (p6_sum_ff),
      .side_in  (p6_side_ff),
      .root_out (sq_root),
      .side_out (sq_side)
   );

   // ---------------- stick test and divider numerator ----------------
   logic [LIM_W:0]   p7_mag_sh;
   logic [LIM_W:0]   p7_num;
   logic [NUM_W-1:0] p7_num_ff;
   logic [MAG_W-1:0] p7_mag_ff;
   side_type         p7_side;
   side_type         p7_side_ff;

   always_comb begin
      p7_mag_sh     = (LIM_W+1)'(sq_root) << FRAC_BITS;
      p7_num        = p7_mag_sh - (LIM_W+1)'(sq_side.lim) + (LIM_W+1)'(sq_root >> 1);
      p7_side       = sq_side;
      // zero magnitude counts as stick, avoiding a divide by zero
      p7_side.stick = (sq_root == '0) || (p7_mag_sh < (LIM_W+1)'(sq_side.lim));
   end

   always_ff @(posedge clock) begin
      if (en[ST_CMP]) begin
         p7_num_ff  <= p7_num[NUM_W-1:0];
         p7_mag_ff  <= sq_root;
         p7_side_ff <= p7_side;
      end
   end

   // ---------------- slide scale factor ----------------
   logic [S_W-1:0] dv_quo;
   side_type       dv_side;

   gncf_div u_div (
      .clock    (clock),
      .en       (en[ST_DIV +: DIV_STAGES]),
      .num_in   (p7_num_ff),
      .den_in   (p7_mag_ff),
      .side_in  (p7_side_ff),
      .quo_out  (dv_quo),
      .side_out (dv_side)
   );

   // ---------------- scale tangents ----------------
   logic signed [SP_W-1:0] p8_prod_ff [3];
   side_type               p8_side_ff;

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         for (int i = 0; i < 3; i++) begin
            p8_prod_ff[i] <= SP_W'($signed(dv_side.tan[i])) * $signed(SP_W'(dv_quo));
         end
         p8_side_ff <= dv_side;
      end
   end

   // ---------------- round, saturate, select ----------------
   logic signed [SP_W-1:0] p9_rnd [3];
   logic [95:0]            p9_data;
   kind_type               p9_kind;
   logic [95:0]            out_data_ff;
   kind_type               out_kind_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p9_rnd[i] = (p8_prod_ff[i] + (SP_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      end
      if (!p8_side_ff.contact) begin
         p9_kind = KIND_PASS;
         p9_data = {p8_side_ff.vel[2], p8_side_ff.vel[1], p8_side_ff.vel[0]};
      end else if (p8_side_ff.stick) begin
         p9_kind = KIND_STICK;
         p9_data = '0;
      end else begin
         p9_kind = KIND_SLIDE;
         p9_data = {sat_vel(SAT_IN_W'(p9_rnd[2])), sat_vel(SAT_IN_W'(p9_rnd[1])),
                    sat_vel(SAT_IN_W'(p9_rnd[0]))};
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         out_data_ff <= p9_data;
         out_kind_ff <= p9_kind;
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_kind_ff;

   // ---------------- assertions ----------------
   a_stick_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STICK |-> rsp_tdata == '0)
      else $error("stuck node with nonzero velocity");

   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[NSTAGE-1] |-> req_tready)
      else $error("input held off while output stage is empty");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && vld_ff == '0)
      else $error("pipeline not flushed by reset");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid node friction collision testbench
// Streams grid nodes through the friction collision block under random
// bursts and result stalls, predicts each velocity projection and contact
// kind in a scoreboard, and sweeps the friction coefficient over its range.
// ----------------------------------------------------------------------------
module tb;
   import gncf_pkg::*;

   localparam int LATENCY   = 58;
   localparam int CYC_LIMIT = 400000;

   // Fixed point projection of one node, held against the stream of results.
   class friction_board;
      logic [31:0] fcoef;
      logic [97:0] pending[$];
      int          errors;
      int          checked;
      int          kinds[3];

      function new();
         fcoef   = 32'(FC_RESET);
         errors  = 0;
         checked = 0;
      endfunction

      function longint rshift_round(longint x);
         return (x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      endfunction

      function longint clamp32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function longint unsigned root_floor(longint unsigned x);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Note one accepted node and queue its expected result.
      function void note_node(logic [183:0] d);
         longint lv, dot, vn, lim, dd, s, mag;
         longint n[3], v[3], t[3], o[3];
         longint unsigned sq;
         kind_type k;
         lv = longint'($signed(d[31:0]));
         for (int i = 0; i < 3; i++) begin
            n[i] = longint'($signed(d[32+18*i +: 18]));
            v[i] = longint'($signed(d[86+32*i +: 32]));
            o[i] = v[i];
         end
         dot = v[0]*n[0] + v[1]*n[1] + v[2]*n[2];
         k = KIND_PASS;
         if (lv <= 0 && dot < 0) begin
            vn = rshift_round(dot);
            sq = 0;
            for (int i = 0; i < 3; i++) begin
               t[i] = clamp32(rshift_round((v[i] <<< FRAC_BITS) - vn*n[i]));
               sq += longint'(t[i]*t[i]);
            end
            mag = longint'(root_floor(sq));
            lim = longint'(fcoef) * (-vn);
            if (mag == 0 || (mag <<< FRAC_BITS) < lim) begin
               k = KIND_STICK;
               for (int i = 0; i < 3; i++) o[i] = 0;
            end else begin
               k = KIND_SLIDE;
               dd = (mag <<< FRAC_BITS) - lim;
               s = (dd + (mag >>> 1)) / mag;
               for (int i = 0; i < 3; i++) o[i] = clamp32(rshift_round(t[i]*s));
            end
         end
         pending.insert(pending.size(), {k, o[2][31:0], o[1][31:0], o[0][31:0]});
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("mismatch %s: got %h expected %h", what, got, want);
      endfunction

      // Check one result beat against the oldest expectation.
      function void check_result(logic [95:0] d, logic [1:0] u);
         logic [97:0] e;
         if (pending.size() == 0) begin
            report("unexpected beat", {30'd0, u}, 32'd0);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e[97:96] < 3) kinds[e[97:96]]++;
         for (int i = 0; i < 3; i++)
            if (d[32*i +: 32] !== e[32*i +: 32])
               report($sformatf("vel_out[%0d]", i), d[32*i +: 32], e[32*i +: 32]);
         if (u !== e[97:96]) report("contact_kind", {30'd0, u}, {30'd0, e[97:96]});
      endfunction
   endclass

   logic         clock, reset;
   logic [183:0] req_tdata;
   logic         req_tvalid, req_tready;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tvalid, rsp_tready;
   logic         csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;
   logic         csr_pready;

   friction_board board;
   int           cycles;
   int           stall_mode;

   grid_node_friction_collision dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   // Sample results at the rising edge.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);

   // Receiver stall pattern: phases of no stall, light and heavy stall.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic csr_write(logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_FRICTION;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.fcoef = value & 32'h7FFFF;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Hold a node until accepted.
   task automatic send_node(logic [183:0] d);
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_node(d);
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   // Drain, then let the pipeline settle before a register write.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic [17:0] rand_normal(int mode);
      case (mode)
         0: return 18'($signed($urandom_range(0, 131072)) - 65536);
         1: return 18'h10000;
         2: return 18'h30000;
         3: return 18'($urandom);
         default: return 18'd0;
      endcase
   endfunction

   function automatic logic [31:0] rand_vel();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 8000000)) - 4000000);
      endcase
   endfunction

   // Mostly contact nodes (inside, some approaching) with random content.
   function automatic logic [183:0] rand_node();
      logic [31:0] lv;
      logic [17:0] nx, ny, nz;
      int m;
      m = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 4);
      case ($urandom_range(0, 5))
         0: lv = $urandom;
         1: lv = 32'd0;
         default: lv = -32'($urandom_range(1, 100000));
      endcase
      nx = rand_normal(m);
      ny = rand_normal($urandom_range(0, 3) == 0 ? 4 : 0);
      nz = rand_normal(m == 3 ? 3 : 0);
      return {rand_vel(), rand_vel(), rand_vel(), nz, ny, nx, lv};
   endfunction

   int sent;

   initial begin
      logic [31:0] fc_set[6];
      board = new();
      cycles = 0;
      sent = 0;
      stall_mode = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed nodes at the reset coefficient.
      send_node({32'd0, 32'd0, 32'hFFFF0000, 18'h0, 18'h0, 18'h10000, 32'd0}); // pure approach, stick
      send_node({32'd0, 32'h00050000, 32'hFFFF0000, 18'h0, 18'h0, 18'h10000,
                 32'hFFFFFFFF});                                              // slide
      send_node({32'd0, 32'd0, 32'h00010000, 18'h0, 18'h0, 18'h10000, 32'hFFFFFFFF}); // separating
      send_node({32'd0, 32'h00050000, 32'hFFFF0000, 18'h0, 18'h0, 18'h10000,
                 32'h00000001});                                              // outside
      send_node({32'h80000000, 32'h7FFFFFFF, 32'h80000000, 18'h10000, 18'h30000,
                 18'h10000, 32'h80000000});                                   // extremes, saturation
      send_node({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 18'h20000, 18'h1FFFF,
                 18'h30000, 32'h80000000});                                   // out-of-range normals
      send_node({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 18'h30000, 18'h30000,
                 18'h30000, 32'h80000000});
      send_node({32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 18'h3FFFF, 18'h3FFFF,
                 18'h3FFFF, 32'h7FFFFFFF});
      send_node('1);
      send_node('0);
      drain();

      fc_set = '{32'h0, 32'h40000, 32'h7FFFF, 32'hFFFFFFFF, 32'h8000, 32'(FC_RESET)};
      foreach (fc_set[p]) begin
         csr_write(fc_set[p]);
         for (int i = 0; i < 190; i++) begin
            if ($urandom_range(0, 7) == 0) drop_valid();
            send_node(rand_node());
            sent++;
         end
         drain();
      end

      $display("covered %0d random nodes over %0d coefficient settings", sent, 6);
      $display("results checked %0d: pass %0d slide %0d stick %0d", board.checked,
               board.kinds[0], board.kinds[1], board.kinds[2]);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
design/gncf_pkg.sv
design/gncf_sqrt.sv
design/gncf_div.sv
design/grid_node_friction_collision.sv
tb/sv/tb.sv
